@@ design/resh_pkg.sv @@
package resh_pkg;

  // Coordinate width of the query and obstacle corners.
  localparam int COORD_BITS = 16;
  // Extents are one bit narrower than coordinates.
  localparam int SIZE_BITS  = COORD_BITS - 1;
  // Snapped edges leave two bits of headroom.
  localparam int OUT_BITS   = COORD_BITS + 2;
  // Internal arithmetic: the widest sum of coordinate, extents and gap never wraps.
  localparam int CALC_BITS  = COORD_BITS + 3;

  localparam int DIST_BITS    = 10;
  localparam int GAP_BITS     = 8;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = DIST_BITS;
  // A kept offset never exceeds the search distance in magnitude.
  localparam int OFS_BITS   = DIST_BITS + 1;

  localparam int NUM_CAND   = 4;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CAPTURE_DIST = 2'd0,
    REG_RELEASE_DIST = 2'd1,
    REG_GAP_PX       = 2'd2
  } cfg_reg_t;

  // Candidate order: near edge with gap, far edge with gap, aligned near, aligned far.
  // Resize mode keeps only the first and the last.
  localparam logic [NUM_CAND-1:0] CAND_EN_MOVE   = 4'b1111;
  localparam logic [NUM_CAND-1:0] CAND_EN_RESIZE = 4'b1001;

  typedef logic signed [CALC_BITS-1:0] calc_t;

  typedef struct packed {
    logic                       found;
    logic signed [OFS_BITS-1:0] offset;
  } best_t;

  function automatic logic [CALC_BITS-1:0] mag(input calc_t v);
    mag = v[CALC_BITS-1] ? CALC_BITS'(-v) : CALC_BITS'(v);
  endfunction

endpackage

@@ design/resh_axis.sv @@
module resh_axis import resh_pkg::*; (
  input  logic                 enable,
  input  logic [NUM_CAND-1:0]  cand_en,
  input  calc_t                cand [NUM_CAND],
  input  logic [DIST_BITS-1:0] reach,
  input  best_t                best_cur,
  output best_t                best_next
);

  best_t                chain [NUM_CAND+1];
  logic [CALC_BITS-1:0] cand_mag [NUM_CAND];
  logic [CALC_BITS-1:0] best_mag [NUM_CAND];
  logic [CALC_BITS-1:0] dist_ext;

  assign dist_ext = CALC_BITS'(reach);

  // Fold the candidates in order; a strict compare keeps the earlier one on a tie.
  always_comb begin
    chain[0] = best_cur;
    for (int i = 0; i < NUM_CAND; i++) begin
      cand_mag[i] = mag(cand[i]);
      best_mag[i] = mag(calc_t'(chain[i].offset));
      if (enable && cand_en[i] && (cand_mag[i] <= dist_ext) &&
          (!chain[i].found || (cand_mag[i] < best_mag[i]))) begin
        chain[i+1].found  = 1'b1;
        chain[i+1].offset = $signed(cand[i][OFS_BITS-1:0]);
      end else begin
        chain[i+1] = chain[i];
      end
    end
  end

  assign best_next = chain[NUM_CAND];

endmodule

@@ design/rect_edge_snap_with_hysteresis_top.sv @@
// Channel  | Handshake                    | Payload
// ---------+------------------------------+---------------------------------------------
// input    | in_valid / in_ready          | resize_mode, pos_*, size_*, obs_*, last_obs
// output   | out_valid / out_ready        | snapped_x, snapped_y, snap_on_x, snap_on_y
// config   | cfg_wr_en (no wait)          | cfg_index, cfg_data
//
// One obstacle per cycle: the input register feeds the per-axis compare chain, which
// folds into the running best offset in the same cycle: one item a cycle unless stalled.
// A last item passes from the input register into the result register unless stalled.
// Reset (synchronous, rst high) clears handshake state, hysteresis and running best;
// the distance and gap registers return to 8, 16 and 0.
// The input side stalls only while a last item waits behind an untaken result.
module rect_edge_snap_with_hysteresis_top import resh_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  // configuration
  input  logic                         cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [CFG_DATA_BITS-1:0]     cfg_data,
  // input channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         resize_mode,
  input  logic signed [COORD_BITS-1:0] pos_x,
  input  logic signed [COORD_BITS-1:0] pos_y,
  input  logic [SIZE_BITS-1:0]         size_w,
  input  logic [SIZE_BITS-1:0]         size_h,
  input  logic signed [COORD_BITS-1:0] obs_x,
  input  logic signed [COORD_BITS-1:0] obs_y,
  input  logic [SIZE_BITS-1:0]         obs_w,
  input  logic [SIZE_BITS-1:0]         obs_h,
  input  logic                         obs_valid,
  input  logic                         last_obs,
  // output channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [OUT_BITS-1:0]   snapped_x,
  output logic signed [OUT_BITS-1:0]   snapped_y,
  output logic                         snap_on_x,
  output logic                         snap_on_y
);

  // Configuration registers
  logic [DIST_BITS-1:0] capture_dist;
  logic [DIST_BITS-1:0] release_dist;
  logic [GAP_BITS-1:0]  gap_px;

  // Input register
  logic                         s_full;
  logic                         s_resize;
  logic signed [COORD_BITS-1:0] s_pos_x, s_pos_y, s_obs_x, s_obs_y;
  logic [SIZE_BITS-1:0]         s_size_w, s_size_h, s_obs_w, s_obs_h;
  logic                         s_obs_valid;
  logic                         s_last;
  logic                         s_adv;

  // Hysteresis and running best
  logic  active_x, active_y;
  best_t best_x, best_y;
  best_t best_x_next, best_y_next;

  // Result register
  logic                       o_full;
  logic signed [OUT_BITS-1:0] o_x, o_y;
  logic                       o_snap_x, o_snap_y;

  // Datapath
  logic [DIST_BITS-1:0] dist_x, dist_y;
  calc_t px, py, w, h, ox, oy, ow, oh, gap, dx, dy;
  calc_t brx, bry, orr, ob;
  logic  near_x, near_y;
  logic  en_x, en_y;
  logic [NUM_CAND-1:0] cand_en;
  calc_t cand_x [NUM_CAND];
  calc_t cand_y [NUM_CAND];
  calc_t adj_x, adj_y, sum_x, sum_y;

  // Configuration writes; an index beyond the list is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      capture_dist <= DIST_BITS'(8);
      release_dist <= DIST_BITS'(16);
      gap_px       <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_CAPTURE_DIST: capture_dist <= cfg_data;
        REG_RELEASE_DIST: release_dist <= cfg_data;
        REG_GAP_PX:       gap_px       <= cfg_data[GAP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // The input register advances unless it holds a last item and the result register
  // is full and not being taken this cycle.
  assign s_adv    = s_full && (!s_last || !o_full || out_ready);
  assign in_ready = !s_full || s_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      s_full <= 1'b1;
    end else if (s_adv) begin
      s_full <= 1'b0;
    end
  end

  // Payload: hold while stalled, load on each transfer.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_resize    <= resize_mode;
      s_pos_x     <= pos_x;
      s_pos_y     <= pos_y;
      s_size_w    <= size_w;
      s_size_h    <= size_h;
      s_obs_x     <= obs_x;
      s_obs_y     <= obs_y;
      s_obs_w     <= obs_w;
      s_obs_h     <= obs_h;
      s_obs_valid <= obs_valid;
      s_last      <= last_obs;
    end
  end

  // Search distance per axis: release distance while that axis snapped on the last query.
  assign dist_x = active_x ? release_dist : capture_dist;
  assign dist_y = active_y ? release_dist : capture_dist;

  assign px  = calc_t'(s_pos_x);
  assign py  = calc_t'(s_pos_y);
  assign w   = calc_t'(s_size_w);
  assign h   = calc_t'(s_size_h);
  assign ox  = calc_t'(s_obs_x);
  assign oy  = calc_t'(s_obs_y);
  assign ow  = calc_t'(s_obs_w);
  assign oh  = calc_t'(s_obs_h);
  assign gap = calc_t'(gap_px);
  assign dx  = calc_t'(dist_x);
  assign dy  = calc_t'(dist_y);

  assign brx = px + w;
  assign bry = py + h;
  assign orr = ox + ow;
  assign ob  = oy + oh;

  // Overlap on the other axis, widened by that axis' own search distance
  assign near_y = (py < ob + dy) && (oy < bry + dy);   // gates the x candidates
  assign near_x = (px < orr + dx) && (ox < brx + dx);  // gates the y candidates

  assign en_x    = s_obs_valid && near_y;
  assign en_y    = s_obs_valid && near_x;
  assign cand_en = s_resize ? CAND_EN_RESIZE : CAND_EN_MOVE;

  // The gapped near edge is the same sum in both modes: obs - gap - (pos + size).
  assign cand_x[0] = ox - gap - brx;
  assign cand_x[1] = orr + gap - px;
  assign cand_x[2] = ox - px;
  assign cand_x[3] = orr - brx;

  assign cand_y[0] = oy - gap - bry;
  assign cand_y[1] = ob + gap - py;
  assign cand_y[2] = oy - py;
  assign cand_y[3] = ob - bry;

  resh_axis u_axis_x (
    .enable    (en_x),
    .cand_en   (cand_en),
    .cand      (cand_x),
    .reach     (dist_x),
    .best_cur  (best_x),
    .best_next (best_x_next)
  );

  resh_axis u_axis_y (
    .enable    (en_y),
    .cand_en   (cand_en),
    .cand      (cand_y),
    .reach     (dist_y),
    .best_cur  (best_y),
    .best_next (best_y_next)
  );

  // Snapped edge from the last item's own query fields
  assign adj_x = best_x_next.found ? calc_t'(best_x_next.offset) : '0;
  assign adj_y = best_y_next.found ? calc_t'(best_y_next.offset) : '0;
  assign sum_x = (s_resize ? brx : px) + adj_x;
  assign sum_y = (s_resize ? bry : py) + adj_y;

  // Running best and hysteresis: fold each advancing item, and on a last item
  // hand the found flags to the hysteresis and start the next query afresh.
  always_ff @(posedge clk) begin
    if (rst) begin
      active_x <= 1'b0;
      active_y <= 1'b0;
      best_x   <= '0;
      best_y   <= '0;
    end else if (s_adv) begin
      if (s_last) begin
        active_x <= best_x_next.found;
        active_y <= best_y_next.found;
        best_x   <= '0;
        best_y   <= '0;
      end else begin
        best_x   <= best_x_next;
        best_y   <= best_y_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_full <= 1'b0;
    end else if (s_adv && s_last) begin
      o_full <= 1'b1;
    end else if (out_ready) begin
      o_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_adv && s_last) begin
      o_x      <= sum_x[OUT_BITS-1:0];
      o_y      <= sum_y[OUT_BITS-1:0];
      o_snap_x <= best_x_next.found;
      o_snap_y <= best_y_next.found;
    end
  end

  assign out_valid = o_full;
  assign snapped_x = o_x;
  assign snapped_y = o_y;
  assign snap_on_x = o_snap_x;
  assign snap_on_y = o_snap_y;

endmodule

@@ design/resh_checker.sv @@
module resh_checker import resh_pkg::*; (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         last_obs,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic signed [OUT_BITS-1:0]   snapped_x,
  input logic signed [OUT_BITS-1:0]   snapped_y,
  input logic                         snap_on_x,
  input logic                         snap_on_y
);

  // A result waiting for its transfer holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(snapped_x) && $stable(snapped_y)
      && $stable(snap_on_x) && $stable(snap_on_y))
    else $error("result changed while stalled");

  // The result register is empty in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid straight after reset");

  // The input side stalls only behind an untaken result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a waiting result");

  // A last item taken with no result waiting is followed by a valid result.
  a_last_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last_obs && !out_valid |-> ##2 out_valid)
    else $error("result missing after last item");

endmodule

bind rect_edge_snap_with_hysteresis_top resh_checker u_resh_checker (.*);

@@ test/snap_checker.sv @@
`timescale 1ns / 1ps

module snap_checker import resh_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [CFG_DATA_BITS-1:0]     cfg_data,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic                         resize_mode,
  input  logic signed [COORD_BITS-1:0] pos_x,
  input  logic signed [COORD_BITS-1:0] pos_y,
  input  logic [SIZE_BITS-1:0]         size_w,
  input  logic [SIZE_BITS-1:0]         size_h,
  input  logic signed [COORD_BITS-1:0] obs_x,
  input  logic signed [COORD_BITS-1:0] obs_y,
  input  logic [SIZE_BITS-1:0]         obs_w,
  input  logic [SIZE_BITS-1:0]         obs_h,
  input  logic                         obs_valid,
  input  logic                         last_obs,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic signed [OUT_BITS-1:0]   snapped_x,
  input  logic signed [OUT_BITS-1:0]   snapped_y,
  input  logic                         snap_on_x,
  input  logic                         snap_on_y,
  output int                           failures,
  output int                           outstanding
);

  typedef struct {
    bit     hit;
    longint ofs;
  } edge_pick_t;

  typedef struct {
    logic signed [OUT_BITS-1:0] x;
    logic signed [OUT_BITS-1:0] y;
    logic                       on_x;
    logic                       on_y;
  } snap_result_t;

  snap_result_t expected_snaps[$];
  snap_result_t want;
  int           mismatch_count = 0;

  longint     capture_d, release_d, gap_d;
  longint     qx, qy, qw, qh, ox, oy, ow, oh, reach_x, reach_y, sx, sy;
  bit         held_x, held_y;
  edge_pick_t run_x, run_y;

  task automatic flag(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Keep the candidate only if it lies within reach and is strictly nearer.
  function automatic edge_pick_t keep_nearer(edge_pick_t cur, longint d, longint reach);
    longint d_mag, best_mag;
    d_mag    = (d < 0) ? -d : d;
    best_mag = (cur.ofs < 0) ? -cur.ofs : cur.ofs;
    if (d_mag <= reach && (!cur.hit || d_mag < best_mag)) begin
      cur.hit = 1'b1;
      cur.ofs = d;
    end
    return cur;
  endfunction

  // Offer one obstacle's edges on one axis in priority order.
  function automatic edge_pick_t scan_axis(edge_pick_t cur, logic resize, longint q_lo,
                                           longint q_ext, longint o_lo, longint o_ext,
                                           longint gap, longint reach);
    longint q_hi, o_hi;
    q_hi = q_lo + q_ext;
    o_hi = o_lo + o_ext;
    cur = keep_nearer(cur, o_lo - gap - q_hi, reach);
    if (!resize) begin
      cur = keep_nearer(cur, o_hi + gap - q_lo, reach);
      cur = keep_nearer(cur, o_lo - q_lo, reach);
    end
    cur = keep_nearer(cur, o_hi - q_hi, reach);
    return cur;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      capture_d = 8;
      release_d = 16;
      gap_d     = 0;
      held_x    = 1'b0;
      held_y    = 1'b0;
      run_x     = '{1'b0, 0};
      run_y     = '{1'b0, 0};
      expected_snaps.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_reg_t'(cfg_index))
          REG_CAPTURE_DIST: capture_d = longint'(cfg_data);
          REG_RELEASE_DIST: release_d = longint'(cfg_data);
          REG_GAP_PX:       gap_d     = longint'(cfg_data[GAP_BITS-1:0]);
          default: ;
        endcase
      end

      if (out_valid && out_ready) begin
        if (expected_snaps.size() == 0) begin
          flag($sformatf("result x=%0d y=%0d with nothing outstanding", snapped_x, snapped_y));
        end else begin
          want = expected_snaps.pop_front();
          if (snapped_x !== want.x)
            flag($sformatf("snapped_x got %0d want %0d", snapped_x, want.x));
          if (snapped_y !== want.y)
            flag($sformatf("snapped_y got %0d want %0d", snapped_y, want.y));
          if (snap_on_x !== want.on_x)
            flag($sformatf("snap_on_x got %b want %b", snap_on_x, want.on_x));
          if (snap_on_y !== want.on_y)
            flag($sformatf("snap_on_y got %b want %b", snap_on_y, want.on_y));
        end
      end

      if (in_valid && in_ready) begin
        qx = longint'(pos_x);
        qy = longint'(pos_y);
        qw = longint'(size_w);
        qh = longint'(size_h);
        ox = longint'(obs_x);
        oy = longint'(obs_y);
        ow = longint'(obs_w);
        oh = longint'(obs_h);
        reach_x = held_x ? release_d : capture_d;
        reach_y = held_y ? release_d : capture_d;
        if (obs_valid) begin
          if (qy < oy + oh + reach_y && oy < qy + qh + reach_y)
            run_x = scan_axis(run_x, resize_mode, qx, qw, ox, ow, gap_d, reach_x);
          if (qx < ox + ow + reach_x && ox < qx + qw + reach_x)
            run_y = scan_axis(run_y, resize_mode, qy, qh, oy, oh, gap_d, reach_y);
        end
        if (last_obs) begin
          sx = (resize_mode ? qx + qw : qx) + (run_x.hit ? run_x.ofs : 0);
          sy = (resize_mode ? qy + qh : qy) + (run_y.hit ? run_y.ofs : 0);
          want.x    = OUT_BITS'(sx);
          want.y    = OUT_BITS'(sy);
          want.on_x = run_x.hit;
          want.on_y = run_y.hit;
          expected_snaps.insert(expected_snaps.size(), want);
          held_x = run_x.hit;
          held_y = run_y.hit;
          run_x  = '{1'b0, 0};
          run_y  = '{1'b0, 0};
        end
      end
    end
    failures    <= mismatch_count;
    outstanding <= expected_snaps.size();
  end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import resh_pkg::*;

  // Cycles to let in-flight items drain once the last result has come back.
  localparam int SETTLE_CYCLES  = 8;
  // Length of the deliberate receiver hold-off.
  localparam int RX_HOLD_CYCLES = 300;
  // Hard stop; far above the slowest legal run.
  localparam int CYCLE_LIMIT    = 400000;

  logic                         clk;
  logic                         rst;
  logic                         cfg_wr_en;
  logic [CFG_IDX_BITS-1:0]      cfg_index;
  logic [CFG_DATA_BITS-1:0]     cfg_data;
  logic                         in_valid;
  logic                         in_ready;
  logic                         resize_mode;
  logic signed [COORD_BITS-1:0] pos_x, pos_y, obs_x, obs_y;
  logic [SIZE_BITS-1:0]         size_w, size_h, obs_w, obs_h;
  logic                         obs_valid;
  logic                         last_obs;
  logic                         out_valid;
  logic                         out_ready;
  logic signed [OUT_BITS-1:0]   snapped_x, snapped_y;
  logic                         snap_on_x, snap_on_y;

  int check_fails;
  int outstanding;

  // One obstacle transfer together with the query rectangle it is tested against.
  typedef struct {
    logic                         resize;
    logic signed [COORD_BITS-1:0] px, py, ox, oy;
    logic [SIZE_BITS-1:0]         w, h, ow, oh;
    logic                         ok, fin;
  } snap_req_t;

  // Shadow of the programmed registers, used only to aim obstacles near the query.
  int cur_cap = 8;
  int cur_rel = 16;
  int cur_gap = 0;

  bit steady        = 1'b0;   // no idling on either side while set
  int rx_hold_asked = 0;      // bumped to request one long receiver hold-off
  int cycle_count   = 0;

  rect_edge_snap_with_hysteresis_top dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .resize_mode(resize_mode), .pos_x(pos_x), .pos_y(pos_y),
    .size_w(size_w), .size_h(size_h),
    .obs_x(obs_x), .obs_y(obs_y), .obs_w(obs_w), .obs_h(obs_h),
    .obs_valid(obs_valid), .last_obs(last_obs),
    .out_valid(out_valid), .out_ready(out_ready),
    .snapped_x(snapped_x), .snapped_y(snapped_y),
    .snap_on_x(snap_on_x), .snap_on_y(snap_on_y)
  );

  snap_checker snap_watch (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .resize_mode(resize_mode), .pos_x(pos_x), .pos_y(pos_y),
    .size_w(size_w), .size_h(size_h),
    .obs_x(obs_x), .obs_y(obs_y), .obs_w(obs_w), .obs_h(obs_h),
    .obs_valid(obs_valid), .last_obs(last_obs),
    .out_valid(out_valid), .out_ready(out_ready),
    .snapped_x(snapped_x), .snapped_y(snapped_y),
    .snap_on_x(snap_on_x), .snap_on_y(snap_on_y),
    .failures(check_fails), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: random back-pressure unless steady is set, and one long
  // hold-off on request so the block backs up and drops in_ready.
  initial begin : rx_side
    int holds_done;
    holds_done = 0;
    out_ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done < rx_hold_asked) begin
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        holds_done++;
      end
      out_ready <= steady || ($urandom_range(99) >= 14);
    end
  end

  function automatic snap_req_t make_item(logic rs, int px, int py, int w, int h,
                                          int ox, int oy, int ow, int oh,
                                          logic ok, logic fin);
    snap_req_t it;
    it.resize = rs;
    it.px  = COORD_BITS'(px);
    it.py  = COORD_BITS'(py);
    it.w   = SIZE_BITS'(w);
    it.h   = SIZE_BITS'(h);
    it.ox  = COORD_BITS'(ox);
    it.oy  = COORD_BITS'(oy);
    it.ow  = SIZE_BITS'(ow);
    it.oh  = SIZE_BITS'(oh);
    it.ok  = ok;
    it.fin = fin;
    return it;
  endfunction

  // New query rectangle: mostly a modest window, now and then anywhere at any size.
  function automatic snap_req_t fresh_query();
    snap_req_t q;
    q.resize = 1'($urandom_range(1));
    if ($urandom_range(9) < 2) begin
      q.px = COORD_BITS'($urandom);
      q.py = COORD_BITS'($urandom);
      q.w  = SIZE_BITS'($urandom);
      q.h  = SIZE_BITS'($urandom);
    end else begin
      q.px = COORD_BITS'(int'($urandom_range(4000)) - 2000);
      q.py = COORD_BITS'(int'($urandom_range(4000)) - 2000);
      q.w  = SIZE_BITS'($urandom_range(300));
      q.h  = SIZE_BITS'($urandom_range(300));
    end
    q.ox  = '0;
    q.oy  = '0;
    q.ow  = '0;
    q.oh  = '0;
    q.ok  = 1'b1;
    q.fin = 1'b0;
    return q;
  endfunction

  // Place an obstacle's low edge so that one candidate offset falls just inside or
  // just outside the search distance, or so the spans merely overlap.
  function automatic longint place_axis(longint q_lo, longint q_ext, longint o_ext);
    int reach, e, pick;
    reach = (cur_cap > cur_rel) ? cur_cap : cur_rel;
    e     = int'($urandom_range(2 * reach + 4)) - reach - 2;
    pick  = int'($urandom_range(4));
    case (pick)
      0:       return q_lo + q_ext + cur_gap + e;
      1:       return q_lo - cur_gap - o_ext + e;
      2:       return q_lo + e;
      3:       return q_lo + q_ext - o_ext + e;
      default: return q_lo - o_ext - reach - 2
                      + longint'($urandom_range(32'(q_ext + o_ext) + 2 * reach + 4));
    endcase
  endfunction

  function automatic snap_req_t with_obstacle(snap_req_t q);
    snap_req_t it;
    it = q;
    if ($urandom_range(99) < 15) begin
      // noise: an obstacle dropped anywhere
      it.ox = COORD_BITS'($urandom);
      it.oy = COORD_BITS'($urandom);
      it.ow = SIZE_BITS'($urandom);
      it.oh = SIZE_BITS'($urandom);
    end else begin
      it.ow = ($urandom_range(9) == 0) ? SIZE_BITS'($urandom) : SIZE_BITS'($urandom_range(300));
      it.oh = ($urandom_range(9) == 0) ? SIZE_BITS'($urandom) : SIZE_BITS'($urandom_range(300));
      it.ox = COORD_BITS'(place_axis(longint'(q.px), longint'(q.w), longint'(it.ow)));
      it.oy = COORD_BITS'(place_axis(longint'(q.py), longint'(q.h), longint'(it.oh)));
    end
    it.ok  = ($urandom_range(9) != 0);
    it.fin = 1'b0;
    return it;
  endfunction

  // Offer one item and hold it until the transfer. Valid drops only for an idle gap,
  // so back-to-back items never see a low-high pair in one step.
  task automatic push_item(input snap_req_t it);
    if (!steady) begin
      while ($urandom_range(99) < 14) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    resize_mode <= it.resize;
    pos_x       <= it.px;
    pos_y       <= it.py;
    size_w      <= it.w;
    size_h      <= it.h;
    obs_x       <= it.ox;
    obs_y       <= it.oy;
    obs_w       <= it.ow;
    obs_h       <= it.oh;
    obs_valid   <= it.ok;
    last_obs    <= it.fin;
    in_valid    <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid, wait for every outstanding result, then let the pipeline empty.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all three registers on consecutive edges; call only while idle.
  task automatic load_config(input int cap, input int rel, input int gap);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_CAPTURE_DIST;
    cfg_data  <= CFG_DATA_BITS'(cap);
    @(posedge clk);
    cfg_index <= REG_RELEASE_DIST;
    cfg_data  <= CFG_DATA_BITS'(rel);
    @(posedge clk);
    cfg_index <= REG_GAP_PX;
    cfg_data  <= CFG_DATA_BITS'(gap);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_cap = cap;
    cur_rel = rel;
    cur_gap = gap;
  endtask

  // Whole queries of random length. Half the time the rectangle is kept so the
  // hysteresis carries over; now and then the query fields change mid-query.
  // With pause_after set, the sender stops once that many items have gone and waits
  // for every result before carrying on.
  task automatic random_queries(input int n_items, input int pause_after);
    snap_req_t q, it;
    int sent, len;
    sent = 0;
    q = fresh_query();
    while (sent < n_items) begin
      if ($urandom_range(1) == 0) q = fresh_query();
      len = ($urandom_range(9) == 0) ? int'($urandom_range(7, 20)) : int'($urandom_range(1, 6));
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(19) == 0) q = fresh_query();
        it = with_obstacle(q);
        it.fin = (k == len - 1);
        push_item(it);
        sent++;
      end
      if (pause_after > 0 && sent >= pause_after) begin
        settle();
        pause_after = 0;
      end
    end
  endtask

  initial begin : stimulus
    snap_req_t it;
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    resize_mode = 1'b0;
    pos_x       = '0;
    pos_y       = '0;
    size_w      = '0;
    size_h      = '0;
    obs_x       = '0;
    obs_y       = '0;
    obs_w       = '0;
    obs_h       = '0;
    obs_valid   = 1'b0;
    last_obs    = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed queries at the reset distances (capture 8, release 16, no gap).
    // Capture at +5, then hold at +12 through release, drop it, and miss +12 afresh.
    push_item(make_item(1'b0, 100, 100, 50, 30, 155, 100, 20, 30, 1'b1, 1'b1));
    push_item(make_item(1'b0, 100, 100, 50, 30, 162, 100, 20, 30, 1'b1, 1'b1));
    push_item(make_item(1'b0, 100, 100, 50, 30, 5000, 5000, 10, 10, 1'b1, 1'b1));
    push_item(make_item(1'b0, 100, 100, 50, 30, 162, 100, 20, 30, 1'b1, 1'b1));
    // Resize snap by the corner, then the same obstacle flagged invalid on a last item.
    push_item(make_item(1'b1, 0, 0, 40, 40, 43, 0, 10, 40, 1'b1, 1'b1));
    push_item(make_item(1'b1, 0, 0, 40, 40, 43, 0, 10, 40, 1'b0, 1'b1));
    // Query rectangle moves inside one query; the result takes the last one's fields.
    push_item(make_item(1'b0, 0, 0, 10, 10, 12, 0, 5, 10, 1'b1, 1'b0));
    push_item(make_item(1'b0, 1000, 1000, 10, 10, -9000, -9000, 3, 3, 1'b1, 1'b1));
    // Equal magnitudes +3 then -3: the earlier one must stay.
    push_item(make_item(1'b0, 100, 100, 10, 10, 113, 100, 4, 10, 1'b1, 1'b0));
    push_item(make_item(1'b0, 100, 100, 10, 10, 97, 100, 30, 10, 1'b1, 1'b1));
    // Coordinate and extent extremes, both modes.
    push_item(make_item(1'b0, -32768, -32768, 32767, 32767, 32767, 32767, 32767, 32767,
                        1'b1, 1'b1));
    push_item(make_item(1'b1, -32768, -32768, 32767, 32767, 32767, 32767, 32767, 32767,
                        1'b1, 1'b1));
    push_item(make_item(1'b0, 32767, 32767, 0, 0, -32768, -32768, 0, 0, 1'b1, 1'b1));
    push_item(make_item(1'b1, 32767, 32767, 32767, 32767, 32767, 32767, 0, 0, 1'b1, 1'b1));
    // Zero-size rectangles lying on top of each other.
    push_item(make_item(1'b0, -5, -5, 0, 0, -5, -5, 0, 0, 1'b1, 1'b1));
    push_item(make_item(1'b0, 32767, -32768, 32767, 0, 32767, -32768, 0, 32767, 1'b1, 1'b1));
    settle();

    // Long stretch with both sides flat out.
    steady = 1'b1;
    random_queries(250, 0);
    settle();
    steady = 1'b0;

    // Zero distance: only exact alignment may snap.
    load_config(0, 0, 0);
    random_queries(200, 0);
    settle();

    // Everything at its maximum.
    load_config(1023, 1023, 255);
    random_queries(200, 0);
    settle();

    // Capture wider than release; the receiver holds off while single-item queries
    // keep coming, so results back up and the input stalls.
    load_config(40, 5, 12);
    rx_hold_asked++;
    repeat (30) begin
      it = with_obstacle(fresh_query());
      it.fin = 1'b1;
      push_item(it);
    end
    random_queries(220, 0);
    settle();

    // Tight capture, wide release; the sender pauses part-way until all results are in.
    load_config(3, 60, 1);
    random_queries(250, 120);
    settle();

    repeat (3) begin
      load_config(int'($urandom_range(1023)), int'($urandom_range(1023)),
                  int'($urandom_range(255)));
      random_queries(180, 0);
      settle();
    end

    if (check_fails == 0 && outstanding == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/resh_pkg.sv
design/resh_axis.sv
design/rect_edge_snap_with_hysteresis_top.sv
design/resh_checker.sv
test/snap_checker.sv
test/testbench.sv
